[hdl/graph_query_lexer_defines.svh]
// Assertion macros shared by the lexer. Each expects clk and rst in scope.
`ifndef GRAPH_QUERY_LEXER_DEFINES_SVH
`define GRAPH_QUERY_LEXER_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define GQL_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define GQL_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

[hdl/gql_pkg.sv]
`default_nettype none

package gql_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_NUM,
    MODE_STR,
    MODE_LT,
    MODE_GT,
    MODE_DASH
  } scan_mode_t;

  localparam logic [4:0] KIND_IDENT   = 5'd0;
  localparam logic [4:0] KIND_NUMBER  = 5'd1;
  localparam logic [4:0] KIND_STRING  = 5'd2;
  localparam logic [4:0] KIND_LPAREN  = 5'd11;
  localparam logic [4:0] KIND_RPAREN  = 5'd12;
  localparam logic [4:0] KIND_LBRACE  = 5'd13;
  localparam logic [4:0] KIND_RBRACE  = 5'd14;
  localparam logic [4:0] KIND_LBRACK  = 5'd15;
  localparam logic [4:0] KIND_RBRACK  = 5'd16;
  localparam logic [4:0] KIND_COLON   = 5'd17;
  localparam logic [4:0] KIND_COMMA   = 5'd18;
  localparam logic [4:0] KIND_DOT     = 5'd19;
  localparam logic [4:0] KIND_EQ      = 5'd20;
  localparam logic [4:0] KIND_GT      = 5'd21;
  localparam logic [4:0] KIND_LT      = 5'd22;
  localparam logic [4:0] KIND_ARROW_L = 5'd23;
  localparam logic [4:0] KIND_ARROW_R = 5'd24;
  localparam logic [4:0] KIND_DASH    = 5'd25;
  localparam logic [4:0] KIND_UNKNOWN = 5'd26;
  localparam logic [4:0] KIND_END     = 5'd27;

  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  localparam int NUM_KEYWORDS = 9;
  localparam logic [8:0] ALL_KEYWORDS = 9'h1FF;

  // Keyword spellings, first letter in the top byte, padded with blanks.
  localparam logic [47:0] KW_TEXT [NUM_KEYWORDS] = '{
    "AS    ", "SET   ", "MATCH ", "WHERE ", "CREATE",
    "RETURN", "DELETE", "DETACH", "UNWIND"
  };
  localparam logic [2:0] KW_LEN [NUM_KEYWORDS] = '{
    3'd2, 3'd3, 3'd5, 3'd5, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6
  };
  localparam logic [4:0] KW_CODE [NUM_KEYWORDS] = '{
    5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd9, 5'd10
  };

  localparam int MAX_TOKENS = 3;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
  } token_t;

  // Tokens produced by one item, packed from slot 0 upwards.
  typedef struct packed {
    logic [1:0]   count;
    token_t [2:0] tok;
  } scan_result_t;

  typedef struct packed {
    logic                     room;
    logic [FIFO_CNT_BITS-1:0] count;
  } fifo_status_t;

  function automatic logic is_alpha(input logic [7:0] b);
    return (b inside {[8'h61:8'h7A], [8'h41:8'h5A]});
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b inside {[8'h30:8'h39]});
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b inside {8'h20, [8'h09:8'h0D]});
  endfunction

  function automatic logic is_word_char(input logic [7:0] b);
    return is_alpha(b) || is_digit(b) || (b == CH_UNDER);
  endfunction

  // Drop keywords whose letter at idx differs from b, or that are too short.
  function automatic logic [8:0] kw_narrow(input logic [8:0] cand, input logic [2:0] idx,
                                           input logic [7:0] b);
    logic [7:0] up;
    logic [8:0] res;
    up  = (b inside {[8'h61:8'h7A]}) ? b - 8'd32 : b;
    res = cand;
    for (int k = 0; k < NUM_KEYWORDS; k++) begin
      if (idx >= KW_LEN[k] || KW_TEXT[k][47 - 8 * int'(idx) -: 8] != up) begin
        res[k] = 1'b0;
      end
    end
    return res;
  endfunction

  // A length of 7 stands for anything longer than six.
  function automatic logic [4:0] word_kind(input logic [8:0] cand, input logic [2:0] len);
    logic [4:0] kind;
    kind = KIND_IDENT;
    for (int k = 0; k < NUM_KEYWORDS; k++) begin
      if (cand[k] && len == KW_LEN[k]) begin
        kind = KW_CODE[k];
      end
    end
    return kind;
  endfunction

  function automatic logic [4:0] single_symbol(input logic [7:0] b);
    logic [4:0] kind;
    case (b)
      8'h28:   kind = KIND_LPAREN;
      8'h29:   kind = KIND_RPAREN;
      8'h7B:   kind = KIND_LBRACE;
      8'h7D:   kind = KIND_RBRACE;
      8'h5B:   kind = KIND_LBRACK;
      8'h5D:   kind = KIND_RBRACK;
      8'h3A:   kind = KIND_COLON;
      8'h2C:   kind = KIND_COMMA;
      CH_DOT:  kind = KIND_DOT;
      CH_EQ:   kind = KIND_EQ;
      default: kind = KIND_UNKNOWN;
    endcase
    return kind;
  endfunction

endpackage

`default_nettype wire

[hdl/graph_query_lexer.sv]
// Channel  Direction  tdata                                   tuser         tlast
// s_*      in         [7:0] text_byte                         byte_present  end_of_text
// m_*      out        [4:0] kind, [20:5] start, [36:21] len   -             last_of_run
//
// One input transfer per cycle while the token queue has room: the byte is held in the input register,
// and its tokens are written into an eight-entry token queue as it leaves that register.
// Output runs at one token per cycle while m_tready is high; input stalls only
// while the queue holds more than five.
// Reset is synchronous and returns the lexer to offset zero in idle mode.
`default_nettype none
`include "graph_query_lexer_defines.svh"

module graph_query_lexer import gql_pkg::*; #(
  parameter int POSITION_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] text_byte
  input  wire logic        s_tuser,   // [0] byte_present
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // [4:0] token_kind, [20:5] start_pos, [36:21] text_length
  output logic             m_tlast
);

  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic         in_present_q;
  logic         in_last_q;
  logic         adv;
  logic [1:0]   push_count;
  scan_result_t scan_res;
  fifo_status_t fifo_stat;
  token_t       out_tok;

  assign adv      = in_valid_q && fifo_stat.room;
  assign s_tready = !in_valid_q || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte_q    <= s_tdata;
      in_present_q <= s_tuser;
      in_last_q    <= s_tlast;
    end
  end

  gql_scan #(
    .POSITION_BITS(POSITION_BITS)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .advance      (adv),
    .text_byte    (in_byte_q),
    .byte_present (in_present_q),
    .end_of_text  (in_last_q),
    .result       (scan_res)
  );

  assign push_count = adv ? scan_res.count : 2'd0;

  gql_token_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .push_tok   (scan_res.tok),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_tok    (out_tok),
    .out_last   (m_tlast),
    .status     (fifo_stat)
  );

  assign m_tdata = {3'b000, out_tok.len, out_tok.start, out_tok.kind};

  `GQL_ASSERT_ALWAYS(a_fifo_bound, fifo_stat.count <= FIFO_CNT_BITS'(FIFO_DEPTH), "token queue overflow")
  `GQL_ASSERT_IMPLY(a_blocked_stall, in_valid_q && !adv, !s_tready, "input taken while stage is held")
  `GQL_ASSERT_IMPLY(a_end_token, adv && in_last_q, push_count != 2'd0, "end of text gave no token")

endmodule

`default_nettype wire

[hdl/gql_scan.sv]
`default_nettype none

module gql_scan import gql_pkg::*; #(
  parameter int POSITION_BITS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         advance,
  input  wire logic [7:0]   text_byte,
  input  wire logic         byte_present,
  input  wire logic         end_of_text,
  output scan_result_t      result
);

  localparam int WideBits = (POSITION_BITS > 16) ? POSITION_BITS : 16;
  localparam logic [POSITION_BITS-1:0] PosMax = '1;

  scan_mode_t               mode, mode_mid, mode_next;
  logic [POSITION_BITS-1:0] lex_start, start_mid, lex_start_next;
  logic [POSITION_BITS-1:0] position, pos_mid, position_next;
  logic [8:0]               cand, cand_mid, cand_next;
  logic                     escape, esc_mid, escape_next;
  logic                     quote_dbl, qd_mid, quote_dbl_next;

  logic [POSITION_BITS-1:0] pos_inc;
  logic [POSITION_BITS-1:0] span_now;
  logic [POSITION_BITS-1:0] str_span_a, str_len_a;
  logic [POSITION_BITS-1:0] span_end, str_len_c;
  logic [2:0]               idx_now, len_end;

  logic   v_a, v_b, v_c, v_d;
  token_t tok_a, tok_b, tok_c, tok_d;

  function automatic logic [15:0] fit16(input logic [POSITION_BITS-1:0] v);
    logic [WideBits-1:0] w;
    w = WideBits'(v);
    return w[15:0];
  endfunction

  function automatic logic [2:0] clamp3(input logic [POSITION_BITS-1:0] v);
    return (v > POSITION_BITS'(6)) ? 3'd7 : v[2:0];
  endfunction

  assign pos_inc    = (position == PosMax) ? PosMax : position + 1'b1;
  assign span_now   = position - lex_start;
  assign idx_now    = clamp3(span_now);
  assign str_span_a = pos_inc - lex_start;
  assign str_len_a  = (str_span_a >= POSITION_BITS'(2)) ? str_span_a - POSITION_BITS'(2) : '0;

  // Byte handling: closes the open lexeme and/or opens a new one.
  always_comb begin
    logic restart;
    restart  = 1'b0;
    mode_mid = mode;
    start_mid = lex_start;
    pos_mid  = position;
    cand_mid = cand;
    esc_mid  = escape;
    qd_mid   = quote_dbl;
    v_a      = 1'b0;
    tok_a    = '0;
    v_b      = 1'b0;
    tok_b    = '0;
    if (byte_present) begin
      case (mode)
        MODE_WORD: begin
          if (is_word_char(text_byte)) begin
            if (position == PosMax) begin
              cand_mid = '0;
            end else begin
              cand_mid = kw_narrow(cand, idx_now, text_byte);
            end
          end else begin
            v_a     = 1'b1;
            tok_a   = '{word_kind(cand, idx_now), fit16(lex_start), fit16(span_now)};
            restart = 1'b1;
          end
        end
        MODE_NUM: begin
          if (!(is_digit(text_byte) || text_byte == CH_DOT)) begin
            v_a     = 1'b1;
            tok_a   = '{KIND_NUMBER, fit16(lex_start), fit16(span_now)};
            restart = 1'b1;
          end
        end
        MODE_STR: begin
          if (escape) begin
            esc_mid = 1'b0;
          end else if (text_byte == CH_BSLASH) begin
            esc_mid = 1'b1;
          end else if (text_byte == (quote_dbl ? CH_DQUOTE : CH_SQUOTE)) begin
            v_a      = 1'b1;
            tok_a    = '{KIND_STRING, fit16(lex_start), fit16(str_len_a)};
            mode_mid = MODE_IDLE;
          end
        end
        MODE_LT: begin
          v_a      = 1'b1;
          mode_mid = MODE_IDLE;
          if (text_byte == CH_DASH) begin
            tok_a = '{KIND_ARROW_L, fit16(lex_start), 16'd2};
          end else if (text_byte == CH_GT) begin
            tok_a = '{KIND_GT, fit16(lex_start), 16'd2};
          end else if (text_byte == CH_EQ) begin
            tok_a = '{KIND_LT, fit16(lex_start), 16'd2};
          end else begin
            tok_a   = '{KIND_LT, fit16(lex_start), 16'd1};
            restart = 1'b1;
          end
        end
        MODE_GT: begin
          v_a      = 1'b1;
          mode_mid = MODE_IDLE;
          if (text_byte == CH_EQ) begin
            tok_a = '{KIND_GT, fit16(lex_start), 16'd2};
          end else begin
            tok_a   = '{KIND_GT, fit16(lex_start), 16'd1};
            restart = 1'b1;
          end
        end
        MODE_DASH: begin
          v_a      = 1'b1;
          mode_mid = MODE_IDLE;
          if (text_byte == CH_GT) begin
            tok_a = '{KIND_ARROW_R, fit16(lex_start), 16'd2};
          end else begin
            tok_a   = '{KIND_DASH, fit16(lex_start), 16'd1};
            restart = 1'b1;
          end
        end
        default: restart = 1'b1;
      endcase

      if (restart) begin
        mode_mid = MODE_IDLE;
        if (!is_space(text_byte)) begin
          start_mid = position;
          if (is_alpha(text_byte) || text_byte == CH_UNDER) begin
            mode_mid = MODE_WORD;
            cand_mid = kw_narrow(ALL_KEYWORDS, 3'd0, text_byte);
          end else if (is_digit(text_byte)) begin
            mode_mid = MODE_NUM;
          end else if (text_byte == CH_SQUOTE || text_byte == CH_DQUOTE) begin
            mode_mid = MODE_STR;
            qd_mid   = (text_byte == CH_DQUOTE);
            esc_mid  = 1'b0;
          end else if (text_byte == CH_LT) begin
            mode_mid = MODE_LT;
          end else if (text_byte == CH_GT) begin
            mode_mid = MODE_GT;
          end else if (text_byte == CH_DASH) begin
            mode_mid = MODE_DASH;
          end else begin
            v_b   = 1'b1;
            tok_b = '{single_symbol(text_byte), fit16(position), 16'd1};
          end
        end
      end
      pos_mid = pos_inc;
    end
  end

  assign span_end  = pos_mid - start_mid;
  assign len_end   = clamp3(span_end);
  assign str_len_c = (span_end >= POSITION_BITS'(2)) ? span_end - POSITION_BITS'(2) : '0;

  // End of text: flush what is open, add the end token and start afresh.
  always_comb begin
    v_c            = 1'b0;
    tok_c          = '0;
    v_d            = end_of_text;
    tok_d          = '{KIND_END, fit16(pos_mid), 16'd0};
    mode_next      = mode_mid;
    lex_start_next = start_mid;
    position_next  = pos_mid;
    cand_next      = cand_mid;
    escape_next    = esc_mid;
    quote_dbl_next = qd_mid;
    if (end_of_text) begin
      case (mode_mid)
        MODE_WORD: begin
          v_c   = 1'b1;
          tok_c = '{word_kind(cand_mid, len_end), fit16(start_mid), fit16(span_end)};
        end
        MODE_NUM: begin
          v_c   = 1'b1;
          tok_c = '{KIND_NUMBER, fit16(start_mid), fit16(span_end)};
        end
        MODE_STR: begin
          v_c   = 1'b1;
          tok_c = '{KIND_STRING, fit16(start_mid), fit16(str_len_c)};
        end
        MODE_LT: begin
          v_c   = 1'b1;
          tok_c = '{KIND_LT, fit16(start_mid), 16'd1};
        end
        MODE_GT: begin
          v_c   = 1'b1;
          tok_c = '{KIND_GT, fit16(start_mid), 16'd1};
        end
        MODE_DASH: begin
          v_c   = 1'b1;
          tok_c = '{KIND_DASH, fit16(start_mid), 16'd1};
        end
        default: v_c = 1'b0;
      endcase
      mode_next      = MODE_IDLE;
      lex_start_next = '0;
      position_next  = '0;
      cand_next      = ALL_KEYWORDS;
      escape_next    = 1'b0;
      quote_dbl_next = 1'b0;
    end
  end

  // At most three of the four slots are ever in use; pack them in order.
  always_comb begin
    logic [2:0] n;
    logic [3:0] v;
    token_t     t [4];
    n = 3'd0;
    v = {v_d, v_c, v_b, v_a};
    t[0] = tok_a;
    t[1] = tok_b;
    t[2] = tok_c;
    t[3] = tok_d;
    result = '0;
    for (int k = 0; k < 4; k++) begin
      if (v[k] && n < 3'(MAX_TOKENS)) begin
        result.tok[n[1:0]] = t[k];
        n = n + 3'd1;
      end
    end
    result.count = n[1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      lex_start <= '0;
      position  <= '0;
      cand      <= ALL_KEYWORDS;
      escape    <= 1'b0;
      quote_dbl <= 1'b0;
    end else if (advance) begin
      mode      <= mode_next;
      lex_start <= lex_start_next;
      position  <= position_next;
      cand      <= cand_next;
      escape    <= escape_next;
      quote_dbl <= quote_dbl_next;
    end
  end

endmodule

`default_nettype wire

[hdl/gql_token_fifo.sv]
`default_nettype none

module gql_token_fifo import gql_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic [1:0]   push_count,
  input  wire token_t [2:0] push_tok,
  output logic              out_valid,
  input  wire logic         out_ready,
  output token_t            out_tok,
  output logic              out_last,
  output fifo_status_t      status
);

  token_t                   entries [FIFO_DEPTH];
  logic                     entry_last [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [FIFO_CNT_BITS-1:0] count;
  logic                     pop;

  assign out_valid    = (count != '0);
  assign pop          = out_valid && out_ready;
  assign out_tok      = entries[rd_ptr];
  assign out_last     = entry_last[rd_ptr];
  // Room for a whole item's worth of tokens, judged on the registered count.
  assign status.room  = (count <= FIFO_CNT_BITS'(FIFO_DEPTH - MAX_TOKENS));
  assign status.count = count;

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_TOKENS; i++) begin
      if (2'(i) < push_count) begin
        entries[wr_ptr + FIFO_PTR_BITS'(i)]    <= push_tok[i];
        entry_last[wr_ptr + FIFO_PTR_BITS'(i)] <= (2'(i) == push_count - 2'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_PTR_BITS'(push_count);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + FIFO_CNT_BITS'(push_count) - FIFO_CNT_BITS'(pop);
    end
  end

endmodule

`default_nettype wire
